// ===== hw/rtl/sca_pkg.sv =====
package sca_pkg;

	// coordinate format: signed fixed point, 8 fraction bits
	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int DET_W       = PROD_W + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [DET_W-1:0]       det_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// the two cross products whose difference gives one orientation
	typedef struct packed {
		prod_t lhs;
		prod_t rhs;
	} orient_terms_t;

	// products and span checks handed from the multiply stage to the decision stage
	typedef struct packed {
		orient_terms_t [3:0] term;
		logic [3:0]          on_span;
	} cross_terms_t;

	typedef enum logic [1:0] {
		ORI_ZERO,
		ORI_POS,
		ORI_NEG
	} orient_t;

endpackage

// ===== hw/rtl/sca_step_if.sv =====
interface sca_step_if;
	import sca_pkg::*;

	logic   valid;
	logic   ready;
	coord_t step_start_x;
	coord_t step_start_y;
	coord_t step_end_x;
	coord_t step_end_y;
	coord_t barrier_start_x;
	coord_t barrier_start_y;
	coord_t barrier_end_x;
	coord_t barrier_end_y;
	logic   final_barrier;

	modport source (
		output valid,
		input  ready,
		output step_start_x, step_start_y, step_end_x, step_end_y,
		output barrier_start_x, barrier_start_y, barrier_end_x, barrier_end_y,
		output final_barrier
	);

	modport sink (
		input  valid,
		output ready,
		input  step_start_x, step_start_y, step_end_x, step_end_y,
		input  barrier_start_x, barrier_start_y, barrier_end_x, barrier_end_y,
		input  final_barrier
	);

endinterface

// ===== hw/rtl/sca_result_if.sv =====
interface sca_result_if;

	logic valid;
	logic ready;
	logic barrier_hit;
	logic any_hit;
	logic list_done;

	modport source (
		output valid,
		input  ready,
		output barrier_hit, any_hit, list_done
	);

	modport sink (
		input  valid,
		output ready,
		input  barrier_hit, any_hit, list_done
	);

endinterface

// ===== hw/rtl/sca_orient.sv =====
module sca_orient (
	input  sca_pkg::point_t       step_a,
	input  sca_pkg::point_t       step_b,
	input  sca_pkg::point_t       bar_c,
	input  sca_pkg::point_t       bar_d,
	output sca_pkg::cross_terms_t terms
);
	import sca_pkg::*;

	// products (q.y-p.y)*(r.x-q.x) and (q.x-p.x)*(r.y-q.y), exact
	function automatic orient_terms_t orient_terms(point_t p, point_t q, point_t r);
		diff_t         dqy;
		diff_t         drx;
		diff_t         dqx;
		diff_t         dry;
		orient_terms_t t;
		dqy   = DIFF_W'(q.y) - DIFF_W'(p.y);
		drx   = DIFF_W'(r.x) - DIFF_W'(q.x);
		dqx   = DIFF_W'(q.x) - DIFF_W'(p.x);
		dry   = DIFF_W'(r.y) - DIFF_W'(q.y);
		t.lhs = PROD_W'(dqy) * PROD_W'(drx);
		t.rhs = PROD_W'(dqx) * PROD_W'(dry);
		return t;
	endfunction

	// q inside the bounding box of p and r
	function automatic logic on_box(point_t p, point_t q, point_t r);
		logic in_x;
		logic in_y;
		in_x = (q.x <= p.x || q.x <= r.x) && (q.x >= p.x || q.x >= r.x);
		in_y = (q.y <= p.y || q.y <= r.y) && (q.y >= p.y || q.y >= r.y);
		return in_x && in_y;
	endfunction

	// four orientations: barrier ends against the step, step ends against the barrier
	always_comb begin
		terms.term[0]    = orient_terms(step_a, step_b, bar_c);
		terms.term[1]    = orient_terms(step_a, step_b, bar_d);
		terms.term[2]    = orient_terms(bar_c, bar_d, step_a);
		terms.term[3]    = orient_terms(bar_c, bar_d, step_b);
		terms.on_span[0] = on_box(step_a, bar_c, step_b);
		terms.on_span[1] = on_box(step_a, bar_d, step_b);
		terms.on_span[2] = on_box(bar_c, step_a, bar_d);
		terms.on_span[3] = on_box(bar_c, step_b, bar_d);
	end

endmodule

// ===== hw/rtl/sca_decide.sv =====
module sca_decide (
	input  sca_pkg::cross_terms_t terms,
	output logic                  hit
);
	import sca_pkg::*;

	orient_t ori [4];
	det_t    det [4];

	// sign of lhs - rhs for each orientation
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			det[i] = DET_W'($signed(terms.term[i].lhs)) - DET_W'($signed(terms.term[i].rhs));
			if (det[i] == '0) begin
				ori[i] = ORI_ZERO;
			end else if (det[i][DET_W-1]) begin
				ori[i] = ORI_NEG;
			end else begin
				ori[i] = ORI_POS;
			end
		end
	end

	// proper crossing, or a collinear endpoint lying on the other segment
	always_comb begin
		hit = (ori[0] != ori[1]) && (ori[2] != ori[3]);
		for (int i = 0; i < 4; i++) begin
			if (ori[i] == ORI_ZERO && terms.on_span[i]) begin
				hit = 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/segment_crossing_any_hit_top.sv =====
// segment crossing test over a streamed list of barriers
//
// step_in carries one beat per barrier: the query step segment, one barrier
// segment and final_barrier, which marks the last barrier of a list. result
// returns one beat per input beat, in order: barrier_hit for this barrier,
// any_hit as the running OR over the list including this beat, and list_done
// as a copy of final_barrier. On a list_done beat any_hit is the answer for
// the whole list, and the running OR is cleared for the next list.
//
// A beat passes from the input register through the product register (eight
// exact signed cross products) to the result register. Throughput is one beat
// per cycle while the receiver accepts results; the 33x33 multiplies and the
// 67-bit subtract that follows them set the stage timing.
//
// Reset clears all valid flags and the running OR; no beat is in flight
// afterwards. When the receiver stalls, the result register holds its beat
// and the stages behind it keep filling; step_in.ready drops only when all
// three stages are full.
module segment_crossing_any_hit_top (
	input logic              clk,
	input logic              arst_n,
	sca_step_if.sink         step_in,
	sca_result_if.source     result
);
	import sca_pkg::*;

	logic         valid_s1;
	point_t       a_s1;
	point_t       b_s1;
	point_t       c_s1;
	point_t       d_s1;
	logic         last_s1;
	logic         valid_s2;
	cross_terms_t terms_s2;
	logic         last_s2;
	logic         out_valid_q;
	logic         hit_q;
	logic         any_q;
	logic         done_q;
	logic         hit_so_far_q;

	cross_terms_t terms_next;
	logic         hit_s2;
	logic         any_s2;
	logic         in_beat;
	logic         adv2;
	logic         adv3;

	// flow control: each stage moves when the one ahead is empty or moving
	assign adv3          = valid_s2 && (!out_valid_q || result.ready);
	assign adv2          = valid_s1 && (!valid_s2 || adv3);
	assign step_in.ready = !valid_s1 || adv2;
	assign in_beat       = step_in.valid && step_in.ready;

	sca_orient u_orient (
		.step_a (a_s1),
		.step_b (b_s1),
		.bar_c  (c_s1),
		.bar_d  (d_s1),
		.terms  (terms_next)
	);

	sca_decide u_decide (
		.terms (terms_s2),
		.hit   (hit_s2)
	);

	assign any_s2 = hit_s2 | hit_so_far_q;

	// valid flags and running OR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
			hit_so_far_q <= 1'b0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= 1'b1;
			end else if (adv3) begin
				valid_s2 <= 1'b0;
			end
			if (adv3) begin
				out_valid_q  <= 1'b1;
				hit_so_far_q <= last_s2 ? 1'b0 : any_s2;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			a_s1.x  <= step_in.step_start_x;
			a_s1.y  <= step_in.step_start_y;
			b_s1.x  <= step_in.step_end_x;
			b_s1.y  <= step_in.step_end_y;
			c_s1.x  <= step_in.barrier_start_x;
			c_s1.y  <= step_in.barrier_start_y;
			d_s1.x  <= step_in.barrier_end_x;
			d_s1.y  <= step_in.barrier_end_y;
			last_s1 <= step_in.final_barrier;
		end
		if (adv2) begin
			terms_s2 <= terms_next;
			last_s2  <= last_s1;
		end
		if (adv3) begin
			hit_q  <= hit_s2;
			any_q  <= any_s2;
			done_q <= last_s2;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.barrier_hit = hit_q;
	assign result.any_hit     = any_q;
	assign result.list_done   = done_q;

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sca_pkg::*;

	localparam int     IDLE_LIMIT   = 2000;
	localparam int     RANDOM_ITEMS = 530;
	localparam int     DRAIN_CYCLES = 10;
	localparam coord_t C_MAX        = 32'sh7fff_ffff;
	localparam coord_t C_MIN        = 32'sh8000_0000;

	// wide enough for exact 33x33 products and their difference
	typedef logic signed [69:0] wide_t;

	typedef struct packed {
		point_t step_from;
		point_t step_to;
		point_t barrier_from;
		point_t barrier_to;
		logic   final_barrier;
	} crossing_item_t;

	typedef struct packed {
		logic barrier_hit;
		logic any_hit;
		logic list_done;
	} verdict_t;

	// crossing predictor and in-order store of expected verdicts
	class crossing_scoreboard;
		verdict_t expected_q[$];
		logic     list_hit;
		int       errors;
		int       beats;
		int       hits;
		int       lists;

		function new();
			list_hit = 1'b0;
			errors   = 0;
			beats    = 0;
			hits     = 0;
			lists    = 0;
		endfunction

		// sign of the cross product of (r - q) and (q - p), exact
		function orient_t orientation(point_t p, point_t q, point_t r);
			wide_t px, py, qx, qy, rx, ry, det;
			px = wide_t'($signed(p.x));
			py = wide_t'($signed(p.y));
			qx = wide_t'($signed(q.x));
			qy = wide_t'($signed(q.y));
			rx = wide_t'($signed(r.x));
			ry = wide_t'($signed(r.y));
			det = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
			if (det > 0)
				return ORI_POS;
			if (det < 0)
				return ORI_NEG;
			return ORI_ZERO;
		endfunction

		// q lies inside the bounding box of p and r
		function bit in_box(point_t p, point_t q, point_t r);
			wide_t px, py, qx, qy, rx, ry;
			px = wide_t'($signed(p.x));
			py = wide_t'($signed(p.y));
			qx = wide_t'($signed(q.x));
			qy = wide_t'($signed(q.y));
			rx = wide_t'($signed(r.x));
			ry = wide_t'($signed(r.y));
			return ((qx >= px && qx <= rx) || (qx >= rx && qx <= px)) &&
				((qy >= py && qy <= ry) || (qy >= ry && qy <= py));
		endfunction

		function bit segments_touch(point_t a, point_t b, point_t c, point_t d);
			orient_t o1, o2, o3, o4;
			o1 = orientation(a, b, c);
			o2 = orientation(a, b, d);
			o3 = orientation(c, d, a);
			o4 = orientation(c, d, b);
			if (o1 != o2 && o3 != o4)
				return 1'b1;
			// collinear: an endpoint resting on the other segment
			if (o1 == ORI_ZERO && in_box(a, c, b))
				return 1'b1;
			if (o2 == ORI_ZERO && in_box(a, d, b))
				return 1'b1;
			if (o3 == ORI_ZERO && in_box(c, a, d))
				return 1'b1;
			if (o4 == ORI_ZERO && in_box(c, b, d))
				return 1'b1;
			return 1'b0;
		endfunction

		function void note_step(crossing_item_t it);
			verdict_t v;
			v.barrier_hit = segments_touch(it.step_from, it.step_to,
				it.barrier_from, it.barrier_to);
			v.any_hit     = v.barrier_hit | list_hit;
			v.list_done   = it.final_barrier;
			list_hit      = it.final_barrier ? 1'b0 : v.any_hit;
			expected_q.push_back(v);
			beats++;
			hits  += v.barrier_hit;
			lists += it.final_barrier;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(verdict_t got);
			verdict_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with no verdict waiting");
				return;
			end
			want = expected_q.pop_front();
			if (got.barrier_hit !== want.barrier_hit)
				report_mismatch($sformatf("barrier_hit expected %0b got %0b",
					want.barrier_hit, got.barrier_hit));
			if (got.any_hit !== want.any_hit)
				report_mismatch($sformatf("any_hit expected %0b got %0b",
					want.any_hit, got.any_hit));
			if (got.list_done !== want.list_done)
				report_mismatch($sformatf("list_done expected %0b got %0b",
					want.list_done, got.list_done));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	int                 cyc;
	int                 idle_cycles;
	int                 stall_left;
	int                 item_no;
	crossing_scoreboard sb;

	sca_step_if   step_bus ();
	sca_result_if result_bus ();

	segment_crossing_any_hit_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.step_in(step_bus),
		.result (result_bus)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 40)) - 20);
			2: begin
				case ($urandom_range(0, 6))
					0: return C_MIN;
					1: return C_MIN + 1;
					2: return -1;
					3: return 0;
					4: return 1;
					5: return C_MAX - 1;
					default: return C_MAX;
				endcase
			end
			default: return coord_t'(int'($urandom_range(0, 65535)) - 32768);
		endcase
	endfunction

	function automatic point_t rand_point(int mode);
		point_t p;
		p.x = rand_coord(mode);
		p.y = rand_coord(mode);
		return p;
	endfunction

	// point a + k*(b - a) on the step's line, wrapped to the 32-bit coordinate width
	function automatic point_t line_point(point_t a, point_t b, int k);
		point_t p;
		p.x = coord_t'(int'(a.x) + k * (int'(b.x) - int'(a.x)));
		p.y = coord_t'(int'(a.y) + k * (int'(b.y) - int'(a.y)));
		return p;
	endfunction

	function automatic crossing_item_t make_item(coord_t sx0, coord_t sy0, coord_t sx1,
			coord_t sy1, coord_t bx0, coord_t by0, coord_t bx1, coord_t by1, logic last);
		crossing_item_t it;
		it.step_from     = '{x: sx0, y: sy0};
		it.step_to       = '{x: sx1, y: sy1};
		it.barrier_from  = '{x: bx0, y: by0};
		it.barrier_to    = '{x: bx1, y: by1};
		it.final_barrier = last;
		return it;
	endfunction

	// one barrier against a fixed step, biased toward hits and boundary cases
	function automatic crossing_item_t random_barrier(point_t a, point_t b, int mode);
		crossing_item_t it;
		point_t         c, d;
		longint         mx, my;
		int             dx, dy, kind;
		kind = $urandom_range(0, 99);
		c = rand_point(mode);
		d = rand_point(mode);
		if (kind < 30) begin
			// independent endpoints
		end else if (kind < 50) begin
			// through the step midpoint
			mx = (longint'($signed(a.x)) + longint'($signed(b.x))) >>> 1;
			my = (longint'($signed(a.y)) + longint'($signed(b.y))) >>> 1;
			dx = int'($urandom_range(0, 128)) - 64;
			dy = int'($urandom_range(0, 128)) - 64;
			c.x = coord_t'(mx + dx);
			c.y = coord_t'(my + dy);
			d.x = coord_t'(mx - dx);
			d.y = coord_t'(my - dy);
		end else if (kind < 70) begin
			// collinear: overlapping, touching, disjoint, shared endpoints
			c = line_point(a, b, int'($urandom_range(0, 5)) - 2);
			d = line_point(a, b, int'($urandom_range(0, 5)) - 2);
		end else if (kind < 80) begin
			// barrier shrunk to a point
			if ($urandom_range(0, 1))
				c = line_point(a, b, int'($urandom_range(0, 3)) - 1);
			d = c;
		end else if (kind < 90) begin
			c = rand_point(2);
			d = rand_point(2);
		end else begin
			// one unit off an endpoint of the step
			c = line_point(a, b, $urandom_range(0, 1));
			if ($urandom_range(0, 1))
				c.x = c.x + ($urandom_range(0, 1) ? 1 : -1);
			else
				c.y = c.y + ($urandom_range(0, 1) ? 1 : -1);
		end
		it.step_from     = a;
		it.step_to       = b;
		it.barrier_from  = c;
		it.barrier_to    = d;
		it.final_barrier = 1'b0;
		return it;
	endfunction

	// present one beat and hold it until accepted; returns at a falling edge
	task automatic send_step(crossing_item_t it);
		step_bus.valid           = 1'b1;
		step_bus.step_start_x    = it.step_from.x;
		step_bus.step_start_y    = it.step_from.y;
		step_bus.step_end_x      = it.step_to.x;
		step_bus.step_end_y      = it.step_to.y;
		step_bus.barrier_start_x = it.barrier_from.x;
		step_bus.barrier_start_y = it.barrier_from.y;
		step_bus.barrier_end_x   = it.barrier_to.x;
		step_bus.barrier_end_y   = it.barrier_to.y;
		step_bus.final_barrier   = it.final_barrier;
		do
			@(posedge clk);
		while (step_bus.ready !== 1'b1);
		sb.note_step(it);
		item_no++;
		@(negedge clk);
	endtask

	// random source gaps outside of steady windows
	task automatic pace_source();
		int n;
		if ((item_no % 150) >= 40 && $urandom_range(0, 99) < 30) begin
			n = gap_length();
			step_bus.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// receiver stalls, with steady windows of no stalls
	initial begin
		result_bus.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && (cyc % 500) >= 120 && $urandom_range(0, 99) < 25)
				stall_left = gap_length();
			if (stall_left > 0) begin
				result_bus.ready = 1'b0;
				stall_left--;
			end else begin
				result_bus.ready = 1'b1;
			end
		end
	end

	// check every accepted result beat
	always @(posedge clk) begin
		verdict_t got;
		if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			got = {result_bus.barrier_hit, result_bus.any_hit, result_bus.list_done};
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		cyc++;
		if ((step_bus.valid === 1'b1 && step_bus.ready === 1'b1) ||
				(result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d verdicts outstanding",
				IDLE_LIMIT, sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		crossing_item_t directed_q[$];
		crossing_item_t it;
		point_t         a, b;
		int             random_sent, list_len, step_mode;

		sb          = new();
		cyc         = 0;
		idle_cycles = 0;
		item_no     = 0;
		random_sent = 0;
		arst_n      = 1'b0;
		step_bus.valid           = 1'b0;
		step_bus.step_start_x    = '0;
		step_bus.step_start_y    = '0;
		step_bus.step_end_x      = '0;
		step_bus.step_end_y      = '0;
		step_bus.barrier_start_x = '0;
		step_bus.barrier_start_y = '0;
		step_bus.barrier_end_x   = '0;
		step_bus.barrier_end_y   = '0;
		step_bus.final_barrier   = 1'b0;

		// reset
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// proper crossing, single-barrier list
		directed_q.push_back(make_item(0, 0, 256, 256, 0, 256, 256, 0, 1'b1));
		// parallel, collinear apart, collinear overlap, tee touch, then a miss
		directed_q.push_back(make_item(0, 0, 100, 0, 0, 5, 100, 5, 1'b0));
		directed_q.push_back(make_item(0, 0, 10, 0, 20, 0, 30, 0, 1'b0));
		directed_q.push_back(make_item(0, 0, 10, 0, 5, 0, 30, 0, 1'b0));
		directed_q.push_back(make_item(0, 0, 10, 0, 5, 0, 5, 9, 1'b0));
		directed_q.push_back(make_item(0, 0, 10, 0, 5, 1, 5, 9, 1'b1));
		// point step on the barrier's extension, then on the barrier, then both points coincide
		directed_q.push_back(make_item(9, 9, 9, 9, 0, 0, 6, 6, 1'b0));
		directed_q.push_back(make_item(3, 3, 3, 3, 0, 0, 6, 6, 1'b0));
		directed_q.push_back(make_item(7, -7, 7, -7, 7, -7, 7, -7, 1'b1));
		// two distinct points: the running OR must have been cleared
		directed_q.push_back(make_item(7, -7, 7, -7, 7, -6, 7, -6, 1'b1));
		// point barrier off and on the step
		directed_q.push_back(make_item(0, 0, 8, 4, 4, 3, 4, 3, 1'b0));
		directed_q.push_back(make_item(0, 0, 8, 4, 4, 2, 4, 2, 1'b1));
		// full-scale coordinates: diagonals, corner points, horizontal and vertical segments
		directed_q.push_back(make_item(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
			1'b1));
		directed_q.push_back(make_item(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
			1'b0));
		directed_q.push_back(make_item(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			1'b1));
		directed_q.push_back(make_item(C_MIN, 0, C_MAX, 0, 0, 0, C_MAX, 0, 1'b1));
		directed_q.push_back(make_item(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX,
			1'b1));
		// nearly through the origin: needs exact products
		directed_q.push_back(make_item(C_MIN, C_MIN + 1, C_MAX, C_MAX, 0, 0, 0, 0, 1'b1));
		directed_q.push_back(make_item(C_MIN, C_MIN + 1, C_MAX, C_MAX, 0, 1, C_MAX, C_MAX,
			1'b1));
		directed_q.push_back(make_item(-1, -1, 0, 0, 0, -1, -1, 0, 1'b1));
		foreach (directed_q[i])
			send_step(directed_q[i]);

		// random lists sharing one step per list
		while (random_sent < RANDOM_ITEMS) begin
			list_len  = $urandom_range(1, 8);
			step_mode = $urandom_range(0, 3);
			a = rand_point(step_mode);
			if ($urandom_range(0, 99) < 8)
				b = a;
			else
				b = rand_point(step_mode);
			for (int k = 0; k < list_len; k++) begin
				it = random_barrier(a, b, step_mode);
				it.final_barrier = (k == list_len - 1);
				pace_source();
				send_step(it);
				random_sent++;
			end
		end
		step_bus.valid = 1'b0;

		// drain
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d step beats over %0d barrier lists, %0d barriers hit",
			sb.beats, sb.lists, sb.hits);
		$display("crossings, touches, collinear and point segments, full-scale coordinates");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
